>>> sv/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

   // field and register widths
   localparam int KIND_W     = 2;
   localparam int ELAPSED_W  = 16;
   localparam int COUNT_W    = 9;
   localparam int PERIOD_W   = 24;
   localparam int MODE_W     = 2;
   localparam int COORD_W    = 20;
   localparam int SIZE_W     = 16;
   localparam int INDEX_W    = 8;
   localparam int ACC_W      = 25;
   localparam int DIR_W      = 2;
   localparam int PROD_W     = INDEX_W + SIZE_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   // default frame count cap
   localparam int MAX_FRAMES = 256;

   // shared divider
   localparam int DIV_W     = 9;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PLAY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

   // bounce direction codes
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_TOTAL_FRAMES   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAMES_PER_ROW = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_PERIOD   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PLAY_MODE      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_X       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_Y       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH    = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT   = 3'd7;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic div_start;
      logic div_pos;
      logic fix;
      logic mul;
      logic write;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mod_needed;
      logic div_done;
      logic out_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

>>> sv/sprite_frame_sequencer.sv
`default_nettype none

// Sprite-sheet frame sequencer. Each request word is a tick (elapsed microseconds are
// added to a saturating 25-bit accumulator, and once it reaches frame_period one period
// is taken off and the frame steps), a play (restart at frame 0, ignored while running
// or when the period is zero) or a stop; every request yields exactly one response word
// with the frame index and its sheet position, origin plus column times width and row
// times height, saturated to 20 bits with 4 fractional bits. Playback is once, loop or
// ping-pong; ping-pong is chosen at play time and only for more than two frames.
// The user must write registers through the csr port only while no request is in flight;
// the block itself does not enforce this. One request is handled at a time: a word that
// steps the frame, unless it steps back below frame 0, first uses the shared restoring
// divider to wrap the stepped index into the frame count, and every word then uses it to
// split the index into row and column. A finished response waits in an output register
// while the next request is accepted.
module sprite_frame_sequencer #(
   parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sfs_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] elapsed_us
   input  wire logic [sfs_pkg::KIND_W-1:0]        req_tuser,  // [1:0] kind

   // response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] play_started, [1] animating, [2] frame_changed, [10:3] frame_index,
   // [30:11] frame_x, [50:31] frame_y, [55:51] zero
   output logic      [sfs_pkg::RSP_DATA_W-1:0]    rsp_tdata,

   // register writes
   input  wire logic                              csr_we,
   input  wire logic [sfs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [sfs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   sfs_pkg::ctl_cmd_type cmd;
   sfs_pkg::ctl_sts_type sts;

   // sequencing of one word through evaluate, wrap, position and write
   sfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // animation state, registers, divider, multipliers and output word
   sfs_dp #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> sv/sfs_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module sfs_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [sfs_pkg::DIV_W-1:0] dividend,
   input  wire logic [sfs_pkg::DIV_W-1:0] divisor,
   output logic      [sfs_pkg::DIV_W-1:0] quotient,
   output logic      [sfs_pkg::DIV_W-1:0] remainder,
   output logic                           done
);

   localparam int W = sfs_pkg::DIV_W;
   localparam int CW = sfs_pkg::DIV_CNT_W;
   localparam logic [CW-1:0] LAST = CW'(W - 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  rem_ff;
   logic [W-1:0]  dsr_ff;

   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          fits;
   logic [W-1:0]  rem_in;

   assign trial  = {rem_ff, quo_ff[W-1]};
   assign diff   = trial - {1'b0, dsr_ff};
   assign fits   = trial >= {1'b0, dsr_ff};
   assign rem_in = fits ? diff[W-1:0] : trial[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

>>> sv/sfs_dp.sv
`default_nettype none

module sfs_dp #(
   parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sfs_pkg::ctl_cmd_type              cmd,
   output sfs_pkg::ctl_sts_type                   sts,
   input  wire logic [sfs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [sfs_pkg::KIND_W-1:0]        req_tuser,
   input  wire logic                              csr_we,
   input  wire logic [sfs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [sfs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [sfs_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int CNT_W = sfs_pkg::COUNT_W;
   localparam int IDX_W = sfs_pkg::INDEX_W;
   localparam int ACC_W = sfs_pkg::ACC_W;
   localparam int CRD_W = sfs_pkg::COORD_W;
   localparam int PRD_W = sfs_pkg::PROD_W;

   // frame count cap, also limited by the 8-bit frame index
   localparam int CAP_INT = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
   localparam logic [CNT_W-1:0] FRAME_CAP = CNT_W'(CAP_INT);

   // configuration registers
   logic [CNT_W-1:0]              total_ff;
   logic [CNT_W-1:0]              per_row_ff;
   logic [sfs_pkg::PERIOD_W-1:0]  period_ff;
   logic [sfs_pkg::MODE_W-1:0]    mode_ff;
   logic [CRD_W-1:0]              origin_x_ff;
   logic [CRD_W-1:0]              origin_y_ff;
   logic [sfs_pkg::SIZE_W-1:0]    width_ff;
   logic [sfs_pkg::SIZE_W-1:0]    height_ff;

   // animation state
   logic                          running_ff, running_in;
   logic [IDX_W-1:0]              cur_ff, cur_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [sfs_pkg::DIR_W-1:0]     dir_ff, dir_in;

   // per-word working registers
   logic [sfs_pkg::KIND_W-1:0]    kind_ff;
   logic [sfs_pkg::ELAPSED_W-1:0] elapsed_ff;
   logic                          started_ff, started_in;
   logic                          changed_ff, changed_in;
   logic                          adv_ff, adv_in;
   logic                          neg_ff, neg_in;
   logic [CNT_W-1:0]              mod_arg_ff, mod_arg_in;
   logic [PRD_W-1:0]              prod_x_ff;
   logic [PRD_W-1:0]              prod_y_ff;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_started_ff;
   logic                          rsp_anim_ff;
   logic                          rsp_changed_ff;
   logic [IDX_W-1:0]              rsp_index_ff;
   logic [CRD_W-1:0]              rsp_x_ff;
   logic [CRD_W-1:0]              rsp_y_ff;

   logic [CNT_W-1:0]              n_eff;
   logic [CNT_W-1:0]              per_eff;
   logic                          looping;
   logic [ACC_W:0]                acc_sum;
   logic [ACC_W-1:0]              acc_sat;
   logic [ACC_W-1:0]              acc_sub;
   logic                          acc_adv;
   logic signed [CNT_W:0]         fix_f;
   logic [sfs_pkg::DIR_W-1:0]     fix_dir;
   logic                          fix_stop;
   logic [CRD_W:0]                sum_x;
   logic [CRD_W:0]                sum_y;
   logic [CRD_W-1:0]              sat_x;
   logic [CRD_W-1:0]              sat_y;

   logic [CNT_W-1:0]              div_dividend;
   logic [CNT_W-1:0]              div_divisor;
   logic [CNT_W-1:0]              div_quo;
   logic [CNT_W-1:0]              div_rem;
   logic                          div_done;

   // frame count: zero counts as one, capped
   assign n_eff   = (total_ff == '0) ? CNT_W'(1) :
                    (total_ff > FRAME_CAP) ? FRAME_CAP : total_ff;
   assign per_eff = (per_row_ff == '0) ? CNT_W'(1) : per_row_ff;
   assign looping = mode_ff[0];

   // saturating accumulate and compare against the period
   assign acc_sum = {1'b0, acc_ff} + {(ACC_W + 1 - sfs_pkg::ELAPSED_W)'(0), elapsed_ff};
   assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
   assign acc_adv = acc_sat >= {1'b0, period_ff};
   assign acc_sub = acc_sat - {1'b0, period_ff};

   assign div_dividend = cmd.div_pos ? {1'b0, cur_ff} : mod_arg_ff;
   assign div_divisor  = cmd.div_pos ? per_eff : n_eff;

   sfs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // wrap handling once the stepped index is known
   always_comb begin
      fix_dir  = dir_ff;
      fix_stop = 1'b0;
      fix_f    = neg_ff ? -(CNT_W + 1)'(1) : $signed({2'b00, div_rem[IDX_W-1:0]});
      if (fix_f == '0) begin
         if (dir_ff == sfs_pkg::DIR_FWD) begin
            // end of forward half: turn around at the second-to-last frame
            fix_dir = sfs_pkg::DIR_REV;
            fix_f   = $signed({1'b0, n_eff}) - (CNT_W + 1)'(2);
         end else if (dir_ff == sfs_pkg::DIR_NONE && !looping) begin
            fix_stop = 1'b1;
         end
      end
      if (!fix_stop && fix_f == -(CNT_W + 1)'(1)) begin
         if (!looping) begin
            fix_stop = 1'b1;
            fix_f    = '0;
         end else begin
            fix_f   = (CNT_W + 1)'(1);
            fix_dir = sfs_pkg::DIR_FWD;
         end
      end
   end

   always_comb begin
      running_in = running_ff;
      cur_in     = cur_ff;
      acc_in     = acc_ff;
      dir_in     = dir_ff;
      started_in = started_ff;
      changed_in = changed_ff;
      adv_in     = adv_ff;
      neg_in     = neg_ff;
      mod_arg_in = mod_arg_ff;
      if (cmd.eval) begin
         started_in = 1'b0;
         changed_in = 1'b0;
         adv_in     = 1'b0;
         neg_in     = 1'b0;
         mod_arg_in = (dir_ff == sfs_pkg::DIR_REV) ? ({1'b0, cur_ff} - CNT_W'(1)) :
                                                     ({1'b0, cur_ff} + CNT_W'(1));
         unique case (kind_ff)
            sfs_pkg::KIND_PLAY: begin
               if (!running_ff && period_ff != '0) begin
                  running_in = 1'b1;
                  cur_in     = '0;
                  acc_in     = '0;
                  dir_in     = (mode_ff[1] && n_eff > CNT_W'(2)) ? sfs_pkg::DIR_FWD :
                                                                   sfs_pkg::DIR_NONE;
                  started_in = 1'b1;
                  changed_in = 1'b1;
               end
            end
            sfs_pkg::KIND_STOP: begin
               running_in = 1'b0;
            end
            sfs_pkg::KIND_TICK: begin
               if (running_ff) begin
                  acc_in = acc_adv ? acc_sub : acc_sat;
                  adv_in = acc_adv;
                  neg_in = acc_adv && dir_ff == sfs_pkg::DIR_REV && cur_ff == '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.fix && adv_ff) begin
         cur_in = fix_f[IDX_W-1:0];
         dir_in = fix_dir;
         if (fix_stop) begin
            running_in = 1'b0;
         end else begin
            changed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         cur_ff     <= '0;
         acc_ff     <= '0;
         dir_ff     <= sfs_pkg::DIR_NONE;
      end else begin
         running_ff <= running_in;
         cur_ff     <= cur_in;
         acc_ff     <= acc_in;
         dir_ff     <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= CNT_W'(1);
         per_row_ff  <= CNT_W'(1);
         period_ff   <= sfs_pkg::PERIOD_W'(16667);
         mode_ff     <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= sfs_pkg::SIZE_W'(256);
         height_ff   <= sfs_pkg::SIZE_W'(256);
      end else if (csr_we) begin
         unique case (csr_addr)
            sfs_pkg::REG_TOTAL_FRAMES:   total_ff    <= csr_wdata[CNT_W-1:0];
            sfs_pkg::REG_FRAMES_PER_ROW: per_row_ff  <= csr_wdata[CNT_W-1:0];
            sfs_pkg::REG_FRAME_PERIOD:   period_ff   <= csr_wdata[sfs_pkg::PERIOD_W-1:0];
            sfs_pkg::REG_PLAY_MODE:      mode_ff     <= csr_wdata[sfs_pkg::MODE_W-1:0];
            sfs_pkg::REG_ORIGIN_X:       origin_x_ff <= csr_wdata[CRD_W-1:0];
            sfs_pkg::REG_ORIGIN_Y:       origin_y_ff <= csr_wdata[CRD_W-1:0];
            sfs_pkg::REG_FRAME_WIDTH:    width_ff    <= csr_wdata[sfs_pkg::SIZE_W-1:0];
            sfs_pkg::REG_FRAME_HEIGHT:   height_ff   <= csr_wdata[sfs_pkg::SIZE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      started_ff <= started_in;
      changed_ff <= changed_in;
      adv_ff     <= adv_in;
      neg_ff     <= neg_in;
      mod_arg_ff <= mod_arg_in;
      if (cmd.load) begin
         kind_ff    <= req_tuser;
         elapsed_ff <= req_tdata[sfs_pkg::ELAPSED_W-1:0];
      end
      // column times width, row times height
      if (cmd.mul) begin
         prod_x_ff <= PRD_W'(div_rem[IDX_W-1:0]) * PRD_W'(width_ff);
         prod_y_ff <= PRD_W'(div_quo[IDX_W-1:0]) * PRD_W'(height_ff);
      end
   end

   // saturating position
   assign sum_x = {1'b0, origin_x_ff} + (CRD_W + 1)'(prod_x_ff);
   assign sum_y = {1'b0, origin_y_ff} + (CRD_W + 1)'(prod_y_ff);
   assign sat_x = (sum_x[CRD_W] || prod_x_ff[PRD_W-1:CRD_W] != '0) ? '1 : sum_x[CRD_W-1:0];
   assign sat_y = (sum_y[CRD_W] || prod_y_ff[PRD_W-1:CRD_W] != '0) ? '1 : sum_y[CRD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rsp_started_ff <= started_ff;
         rsp_anim_ff    <= running_ff;
         rsp_changed_ff <= changed_ff;
         rsp_index_ff   <= cur_ff;
         rsp_x_ff       <= sat_x;
         rsp_y_ff       <= sat_y;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(sfs_pkg::RSP_DATA_W - 2 * CRD_W - IDX_W - 3)'(0),
                        rsp_y_ff, rsp_x_ff, rsp_index_ff,
                        rsp_changed_ff, rsp_anim_ff, rsp_started_ff};

   assign sts.mod_needed = adv_ff && !neg_ff;
   assign sts.div_done   = div_done;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   // a result is only written into a free or draining output register
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over a pending word");

   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> rsp_valid_ff)
      else $error("written result not presented");

   // a started animation reports frame zero, running and changed
   a_start_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_started_ff) |->
         (rsp_anim_ff && rsp_changed_ff && rsp_index_ff == '0))
      else $error("play start result inconsistent");

   // stepped index from the divider lies inside the frame count
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.fix && adv_ff && !neg_ff) |-> (div_rem < n_eff))
      else $error("stepped frame index out of range");

endmodule

`default_nettype wire

>>> sv/sfs_ctrl.sv
`default_nettype none

module sfs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire sfs_pkg::ctl_sts_type sts,
   output sfs_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_EVAL     = 9'b000000010,
      ST_MOD_GO   = 9'b000000100,
      ST_MOD_WAIT = 9'b000001000,
      ST_FIX      = 9'b000010000,
      ST_POS_GO   = 9'b000100000,
      ST_POS_WAIT = 9'b001000000,
      ST_MUL      = 9'b010000000,
      ST_WRITE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_MOD_GO;
         end
         // wrap the stepped index into the frame count when a step happened that does not go below frame zero
         ST_MOD_GO: begin
            if (sts.mod_needed) begin
               cmd.div_start = 1'b1;
               state_in      = ST_MOD_WAIT;
            end else begin
               state_in = ST_FIX;
            end
         end
         ST_MOD_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_POS_GO;
         end
         // row and column of the current frame
         ST_POS_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_pos   = 1'b1;
            state_in      = ST_POS_WAIT;
         end
         ST_POS_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
